// ===== hdl/cdl_pkg.sv =====
// Shared types, codes and character constants for the configuration directive lexer.
`timescale 1ns / 1ps
`default_nettype none

package cdl_pkg;

  // Default sizing of the lexer
  localparam int DEF_MAX_DEPTH = 15;
  localparam int DEF_LINE_BITS = 16;

  // Fixed widths of the result fields
  localparam int OUT_LINE_W  = 16;
  localparam int OUT_DEPTH_W = 4;

  // Characters the lexer reacts to
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_DIR   = 3'd1,
    EV_OPEN  = 3'd2,
    EV_CLOSE = 3'd3,
    EV_DONE  = 3'd4,
    EV_ERR   = 3'd5,
    EV_HALT  = 3'd6
  } cdl_event_t;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_QUOTE_CHAR   = 4'd1,
    ERR_LONE_SEMI    = 4'd2,
    ERR_LONE_BRACE   = 4'd3,
    ERR_CLOSE_WORDS  = 4'd4,
    ERR_EOF_DIR      = 4'd5,
    ERR_EMPTY_DIR    = 4'd6,
    ERR_STRAY_CLOSE  = 4'd7,
    ERR_EOF_BLOCK    = 4'd8,
    ERR_DEPTH        = 4'd9
  } cdl_error_t;

  // Token-level flags of the lexer
  typedef struct packed {
    logic in_comment;
    logic in_dquote;
    logic in_squote;
    logic need_sep;
    logic after_sep;
    logic word_text;
    logic have_words;
  } cdl_flags_t;

  localparam cdl_flags_t FLAGS_CLEAR = '{
    in_comment: 1'b0, in_dquote: 1'b0, in_squote: 1'b0, need_sep: 1'b0,
    after_sep: 1'b1, word_text: 1'b0, have_words: 1'b0
  };

  // Per-item status bits and codes
  typedef struct packed {
    logic       is_word_text;
    logic       word_done;
    cdl_event_t event_res;
    cdl_error_t error_code;
  } cdl_status_t;

  // Word separators: space, tab, CR, LF
  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cdl_if.sv =====
// Request and result channel interfaces of the lexer.
`timescale 1ns / 1ps
`default_nettype none

interface cdl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface cdl_out_if import cdl_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic                   is_word_text;
  logic                   word_done;
  logic [2:0]             event_res;
  logic [3:0]             error_code;
  logic [OUT_LINE_W-1:0]  line_number;
  logic [OUT_LINE_W-1:0]  directive_line;
  logic [OUT_DEPTH_W-1:0] nest_depth;

  modport source (output valid, output is_word_text, output word_done, output event_res,
                  output error_code, output line_number, output directive_line,
                  output nest_depth, input ready);
  modport sink   (input valid, input is_word_text, input word_done, input event_res,
                  input error_code, input line_number, input directive_line,
                  input nest_depth, output ready);
endinterface

`default_nettype wire

// ===== hdl/cdl_step.sv =====
// Combinational per-item update of the lexer state and its result fields.
`timescale 1ns / 1ps
`default_nettype none

module cdl_step import cdl_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  parameter int LINE_BITS = DEF_LINE_BITS,
  localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic                   kind,
  input  wire logic [7:0]             c,
  input  wire cdl_flags_t             flags,
  input  wire logic [LINE_BITS-1:0]   line_cnt,
  input  wire logic [LINE_BITS-1:0]   first_line,
  input  wire logic [DEPTH_W-1:0]     depth,
  input  wire logic                   halted,
  output cdl_flags_t                  flags_nxt,
  output logic [LINE_BITS-1:0]        line_nxt,
  output logic [LINE_BITS-1:0]        first_nxt,
  output logic [DEPTH_W-1:0]          depth_nxt,
  output logic                        halted_nxt,
  output cdl_status_t                 status,
  output logic [OUT_LINE_W-1:0]       line_out,
  output logic [OUT_LINE_W-1:0]       dline_out,
  output logic [OUT_DEPTH_W-1:0]      depth_out
);

  cdl_event_t           ev;
  cdl_error_t           err;
  logic                 text;
  logic                 done;
  logic                 ended;
  logic [LINE_BITS-1:0] dline;
  logic [31:0]          line_w;
  logic [31:0]          dline_w;
  logic [31:0]          depth_w;

  // Flag, counter and event update for one item
  always_comb begin
    flags_nxt  = flags;
    line_nxt   = line_cnt;
    first_nxt  = first_line;
    depth_nxt  = depth;
    halted_nxt = halted;
    ev         = EV_NONE;
    err        = ERR_NONE;
    text       = 1'b0;
    done       = 1'b0;
    ended      = 1'b0;
    dline      = first_line;

    if (halted) begin
      ev = EV_HALT;
    end else if (kind == KIND_EOF) begin
      if (flags.have_words || !flags.after_sep) begin
        ev  = EV_ERR;
        err = ERR_EOF_DIR;
      end else if (depth != '0) begin
        ev  = EV_ERR;
        err = ERR_EOF_BLOCK;
      end else begin
        ev = EV_DONE;
      end
    end else begin
      // line feed: count line (saturating) and end a comment
      if (c == CH_LF) begin
        if (line_cnt != '1) line_nxt = line_cnt + 1'b1;
        flags_nxt.in_comment = 1'b0;
      end

      if (flags_nxt.in_comment) begin
        // comment text is skipped
      end else if (flags.need_sep) begin
        if (is_sep(c)) begin
          flags_nxt.after_sep = 1'b1;
          flags_nxt.need_sep  = 1'b0;
        end else if (c == CH_SEMI) begin
          ev = EV_DIR;
        end else if (c == CH_LBRACE) begin
          ev = EV_OPEN;
        end else begin
          ev  = EV_ERR;
          err = ERR_QUOTE_CHAR;
        end
      end else if (flags.after_sep) begin
        if (is_sep(c)) begin
          // extra separator
        end else if (c == CH_SEMI) begin
          if (flags.have_words) begin
            ev = EV_DIR;
          end else begin
            ev  = EV_ERR;
            err = ERR_LONE_SEMI;
          end
        end else if (c == CH_LBRACE) begin
          if (flags.have_words) begin
            ev = EV_OPEN;
          end else begin
            ev  = EV_ERR;
            err = ERR_LONE_BRACE;
          end
        end else if (c == CH_RBRACE) begin
          if (flags.have_words) begin
            ev  = EV_ERR;
            err = ERR_CLOSE_WORDS;
          end else begin
            ev = EV_CLOSE;
          end
        end else if (c == CH_HASH) begin
          flags_nxt.in_comment = 1'b1;
        end else begin
          // start of a word
          if (first_line == '0) first_nxt = line_nxt;
          flags_nxt.after_sep = 1'b0;
          if (c == CH_DQUOTE) begin
            flags_nxt.in_dquote = 1'b1;
          end else if (c == CH_SQUOTE) begin
            flags_nxt.in_squote = 1'b1;
          end else begin
            text                = 1'b1;
            flags_nxt.word_text = 1'b1;
          end
        end
      end else begin
        // inside a word
        if (first_line == '0) first_nxt = line_nxt;
        if (flags.in_dquote) begin
          if (c == CH_DQUOTE) begin
            flags_nxt.in_dquote = 1'b0;
            flags_nxt.need_sep  = 1'b1;
            ended               = 1'b1;
          end else begin
            text = 1'b1;
          end
        end else if (flags.in_squote) begin
          if (c == CH_SQUOTE) begin
            flags_nxt.in_squote = 1'b0;
            flags_nxt.need_sep  = 1'b1;
            ended               = 1'b1;
          end else begin
            text = 1'b1;
          end
        end else if (is_sep(c) || c == CH_SEMI || c == CH_LBRACE) begin
          flags_nxt.after_sep = 1'b1;
          ended               = 1'b1;
        end else begin
          text = 1'b1;
        end
        if (text) flags_nxt.word_text = 1'b1;
        if (ended) begin
          if (flags.word_text) begin
            done                 = 1'b1;
            flags_nxt.have_words = 1'b1;
          end
          flags_nxt.word_text = 1'b0;
          if (c == CH_SEMI) ev = EV_DIR;
          else if (c == CH_LBRACE) ev = EV_OPEN;
        end
      end

      dline = first_nxt;

      // directive made only of empty quoted words
      if ((ev == EV_DIR || ev == EV_OPEN) && !flags_nxt.have_words) begin
        ev  = EV_ERR;
        err = ERR_EMPTY_DIR;
      end

      // block depth tracking
      if (ev == EV_OPEN) begin
        if (depth >= DEPTH_W'(MAX_DEPTH)) begin
          ev  = EV_ERR;
          err = ERR_DEPTH;
        end else begin
          depth_nxt = depth + 1'b1;
        end
      end else if (ev == EV_CLOSE) begin
        if (depth == '0) begin
          ev  = EV_ERR;
          err = ERR_STRAY_CLOSE;
        end else begin
          depth_nxt = depth - 1'b1;
        end
      end

      // directive boundary resets the token state
      if (ev == EV_DIR || ev == EV_OPEN || ev == EV_CLOSE) begin
        flags_nxt = FLAGS_CLEAR;
        first_nxt = '0;
      end
    end

    if (ev == EV_DONE || ev == EV_ERR) halted_nxt = 1'b1;
  end

  // Result fields, resized to the channel widths
  assign line_w  = 32'(line_nxt);
  assign dline_w = 32'(dline);
  assign depth_w = 32'(depth_nxt);

  assign status.is_word_text = text;
  assign status.word_done    = done;
  assign status.event_res    = ev;
  assign status.error_code   = err;
  assign line_out            = line_w[OUT_LINE_W-1:0];
  assign dline_out           = dline_w[OUT_LINE_W-1:0];
  assign depth_out           = depth_w[OUT_DEPTH_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/config_directive_lexer.sv =====
// Top level of the configuration directive lexer: input register, state and result register.
// A request passes the input register, then the result register, before its result is valid.
// One request per cycle unless stalled; each flag update is one shallow combinational pass.
// Each request yields exactly one result; both stages hold under back-pressure.
// Reset (rst_n low, synchronous) clears both stages and sets line 1, depth 0, no words.
// Done and error stay sticky until reset; later requests report halted.
`timescale 1ns / 1ps
`default_nettype none

module config_directive_lexer import cdl_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  parameter int LINE_BITS = DEF_LINE_BITS
) (
  input wire logic   clk,
  input wire logic   rst_n,
  cdl_in_if.sink     in_req,
  cdl_out_if.source  out_res
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  // Input stage
  logic       in_vld_r;
  logic       kind_r;
  logic [7:0] byte_r;

  // Lexer state
  cdl_flags_t           flags_r;
  logic [LINE_BITS-1:0] line_r;
  logic [LINE_BITS-1:0] first_r;
  logic [DEPTH_W-1:0]   depth_r;
  logic                 halted_r;

  // Result stage
  logic                   out_vld_r;
  cdl_status_t            status_r;
  logic [OUT_LINE_W-1:0]  line_out_r;
  logic [OUT_LINE_W-1:0]  dline_out_r;
  logic [OUT_DEPTH_W-1:0] depth_out_r;

  // Step outputs
  cdl_flags_t             flags_nxt;
  logic [LINE_BITS-1:0]   line_nxt;
  logic [LINE_BITS-1:0]   first_nxt;
  logic [DEPTH_W-1:0]     depth_nxt;
  logic                   halted_nxt;
  cdl_status_t            status_nxt;
  logic [OUT_LINE_W-1:0]  line_out_nxt;
  logic [OUT_LINE_W-1:0]  dline_out_nxt;
  logic [OUT_DEPTH_W-1:0] depth_out_nxt;

  logic out_load;
  logic adv;

  // Pipeline flow: result register frees up when empty or taken
  assign out_load     = !out_vld_r || out_res.ready;
  assign adv          = in_vld_r && out_load;
  assign in_req.ready = !in_vld_r || out_load;

  cdl_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .LINE_BITS (LINE_BITS)
  ) u_step (
    .kind       (kind_r),
    .c          (byte_r),
    .flags      (flags_r),
    .line_cnt   (line_r),
    .first_line (first_r),
    .depth      (depth_r),
    .halted     (halted_r),
    .flags_nxt  (flags_nxt),
    .line_nxt   (line_nxt),
    .first_nxt  (first_nxt),
    .depth_nxt  (depth_nxt),
    .halted_nxt (halted_nxt),
    .status     (status_nxt),
    .line_out   (line_out_nxt),
    .dline_out  (dline_out_nxt),
    .depth_out  (depth_out_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_req.ready) begin
      in_vld_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      kind_r <= in_req.kind;
      byte_r <= in_req.text_byte;
    end
  end

  // Lexer state, updated as a request moves to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= FLAGS_CLEAR;
      line_r   <= LINE_BITS'(1);
      first_r  <= '0;
      depth_r  <= '0;
      halted_r <= 1'b0;
    end else if (adv) begin
      flags_r  <= flags_nxt;
      line_r   <= line_nxt;
      first_r  <= first_nxt;
      depth_r  <= depth_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r    <= status_nxt;
      line_out_r  <= line_out_nxt;
      dline_out_r <= dline_out_nxt;
      depth_out_r <= depth_out_nxt;
    end
  end

  assign out_res.valid          = out_vld_r;
  assign out_res.is_word_text   = status_r.is_word_text;
  assign out_res.word_done      = status_r.word_done;
  assign out_res.event_res      = status_r.event_res;
  assign out_res.error_code     = status_r.error_code;
  assign out_res.line_number    = line_out_r;
  assign out_res.directive_line = dline_out_r;
  assign out_res.nest_depth     = depth_out_r;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of the configuration directive lexer.
`timescale 1ns / 1ps

module tb;
  import cdl_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RAND_ITEMS   = 600;
  localparam int DRAIN_CYCLES = 12;
  localparam int LINE_TOP     = (1 << DEF_LINE_BITS) - 1;

  // How a generated directive is terminated
  localparam int END_ANY  = 0;
  localparam int END_OPEN = 1;
  localparam int END_SEMI = 2;

  // Stream endings, one per run
  localparam int FIN_DONE        = 0;
  localparam int FIN_QUOTE_CHAR  = 1;
  localparam int FIN_LONE_SEMI   = 2;
  localparam int FIN_LONE_BRACE  = 3;
  localparam int FIN_CLOSE_WORDS = 4;
  localparam int FIN_EOF_DIR     = 5;
  localparam int FIN_EMPTY_DIR   = 6;
  localparam int FIN_STRAY_CLOSE = 7;
  localparam int FIN_EOF_BLOCK   = 8;
  localparam int FIN_DEPTH       = 9;

  typedef struct packed {
    logic        is_word_text;
    logic        word_done;
    cdl_event_t  ev;
    cdl_error_t  err;
    logic [15:0] line;
    logic [15:0] dline;
    logic [3:0]  depth;
  } lex_result_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  b;
    logic        typed;
    lex_result_t want;
  } stim_row_t;

  localparam lex_result_t NO_WANT = '0;

  // Directed opening: words, quotes, comments, braces inside words, open/close
  localparam stim_row_t DIR_TAB [25] = '{
    '{KIND_BYTE, 8'h61, 1'b1, '{1'b1, 1'b0, EV_NONE, ERR_NONE, 16'd1, 16'd1, 4'd0}},
    '{KIND_BYTE, 8'hFF, 1'b1, '{1'b1, 1'b0, EV_NONE, ERR_NONE, 16'd1, 16'd1, 4'd0}},
    '{KIND_BYTE, CH_SPACE, 1'b1, '{1'b0, 1'b1, EV_NONE, ERR_NONE, 16'd1, 16'd1, 4'd0}},
    '{KIND_BYTE, CH_DQUOTE, 1'b0, NO_WANT},
    '{KIND_BYTE, 8'h00, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_DQUOTE, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_LBRACE, 1'b1, '{1'b0, 1'b0, EV_OPEN, ERR_NONE, 16'd1, 16'd1, 4'd1}},
    '{KIND_BYTE, CH_LF, 1'b1, '{1'b0, 1'b0, EV_NONE, ERR_NONE, 16'd2, 16'd0, 4'd1}},
    '{KIND_BYTE, CH_HASH, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_SEMI, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_LF, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_SQUOTE, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_DQUOTE, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_SQUOTE, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_TAB, 1'b0, NO_WANT},
    '{KIND_BYTE, 8'h62, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_RBRACE, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_HASH, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_SEMI, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_CR, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_RBRACE, 1'b1, '{1'b0, 1'b0, EV_CLOSE, ERR_NONE, 16'd3, 16'd0, 4'd0}},
    '{KIND_BYTE, 8'h78, 1'b0, NO_WANT},
    '{KIND_BYTE, 8'h80, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_LBRACE, 1'b0, NO_WANT},
    '{KIND_BYTE, CH_RBRACE, 1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst_n;

  cdl_in_if  in_req ();
  cdl_out_if out_res ();

  config_directive_lexer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #6 clk = ~clk;

  // Lexer state mirrored by the predictor
  bit lx_comment    = 1'b0;
  bit lx_dq         = 1'b0;
  bit lx_sq         = 1'b0;
  bit lx_need_sep   = 1'b0;
  bit lx_after_sep  = 1'b1;
  bit lx_word_text  = 1'b0;
  bit lx_have_words = 1'b0;
  bit lx_halted     = 1'b0;
  int lx_line       = 1;
  int lx_first      = 0;
  int lx_depth      = 0;

  lex_result_t owed_results [$];
  int          sent;
  int          checked;
  int          fails;
  int          cycles;
  int          deepest;
  bit          steady;
  cdl_event_t  close_ev  = EV_NONE;
  cdl_error_t  close_err = ERR_NONE;

  function automatic bit blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic bit starts_word(input logic [7:0] c);
    return !(blank(c) || c == CH_SEMI || c == CH_LBRACE || c == CH_RBRACE ||
             c == CH_HASH || c == CH_DQUOTE || c == CH_SQUOTE);
  endfunction

  // Append one expected result at the tail of the queue
  task automatic owe_result(input lex_result_t r);
    owed_results = {owed_results, r};
  endtask

  // Advance the mirrored lexer by one request and return its result
  task automatic lex_byte_result(input logic kind, input logic [7:0] c, output lex_result_t r);
    cdl_event_t ev;
    cdl_error_t err;
    bit         text;
    bit         fin;
    bit         ended;
    int         dline;
    ev = EV_NONE;
    err = ERR_NONE;
    text = 1'b0;
    fin = 1'b0;
    ended = 1'b0;
    dline = lx_first;
    if (lx_halted) begin
      ev = EV_HALT;
    end else if (kind == KIND_EOF) begin
      if (lx_have_words || !lx_after_sep) begin
        ev = EV_ERR;
        err = ERR_EOF_DIR;
      end else if (lx_depth != 0) begin
        ev = EV_ERR;
        err = ERR_EOF_BLOCK;
      end else begin
        ev = EV_DONE;
      end
    end else begin
      if (c == CH_LF) begin
        if (lx_line < LINE_TOP) lx_line++;
        lx_comment = 1'b0;
      end
      if (!lx_comment) begin
        if (lx_need_sep) begin
          // closing quote must be followed by a separator or a terminator
          if (blank(c)) begin
            lx_after_sep = 1'b1;
            lx_need_sep = 1'b0;
          end else if (c == CH_SEMI) begin
            ev = EV_DIR;
          end else if (c == CH_LBRACE) begin
            ev = EV_OPEN;
          end else begin
            ev = EV_ERR;
            err = ERR_QUOTE_CHAR;
          end
        end else if (lx_after_sep) begin
          // between words
          if (blank(c)) begin
          end else if (c == CH_SEMI) begin
            if (lx_have_words) ev = EV_DIR;
            else begin
              ev = EV_ERR;
              err = ERR_LONE_SEMI;
            end
          end else if (c == CH_LBRACE) begin
            if (lx_have_words) ev = EV_OPEN;
            else begin
              ev = EV_ERR;
              err = ERR_LONE_BRACE;
            end
          end else if (c == CH_RBRACE) begin
            if (lx_have_words) begin
              ev = EV_ERR;
              err = ERR_CLOSE_WORDS;
            end else begin
              ev = EV_CLOSE;
            end
          end else if (c == CH_HASH) begin
            lx_comment = 1'b1;
          end else begin
            if (lx_first == 0) lx_first = lx_line;
            lx_after_sep = 1'b0;
            if (c == CH_DQUOTE) lx_dq = 1'b1;
            else if (c == CH_SQUOTE) lx_sq = 1'b1;
            else begin
              text = 1'b1;
              lx_word_text = 1'b1;
            end
          end
        end else begin
          // inside a word
          if (lx_first == 0) lx_first = lx_line;
          if (lx_dq) begin
            if (c == CH_DQUOTE) begin
              lx_dq = 1'b0;
              lx_need_sep = 1'b1;
              ended = 1'b1;
            end else begin
              text = 1'b1;
            end
          end else if (lx_sq) begin
            if (c == CH_SQUOTE) begin
              lx_sq = 1'b0;
              lx_need_sep = 1'b1;
              ended = 1'b1;
            end else begin
              text = 1'b1;
            end
          end else if (blank(c) || c == CH_SEMI || c == CH_LBRACE) begin
            lx_after_sep = 1'b1;
            ended = 1'b1;
          end else begin
            text = 1'b1;
          end
          if (text) lx_word_text = 1'b1;
          if (ended) begin
            if (lx_word_text) begin
              fin = 1'b1;
              lx_have_words = 1'b1;
            end
            lx_word_text = 1'b0;
            if (c == CH_SEMI) ev = EV_DIR;
            else if (c == CH_LBRACE) ev = EV_OPEN;
          end
        end
      end
      dline = lx_first;
      if ((ev == EV_DIR || ev == EV_OPEN) && !lx_have_words) begin
        ev = EV_ERR;
        err = ERR_EMPTY_DIR;
      end
      if (ev == EV_OPEN) begin
        if (lx_depth >= DEF_MAX_DEPTH) begin
          ev = EV_ERR;
          err = ERR_DEPTH;
        end else begin
          lx_depth++;
        end
      end else if (ev == EV_CLOSE) begin
        if (lx_depth == 0) begin
          ev = EV_ERR;
          err = ERR_STRAY_CLOSE;
        end else begin
          lx_depth--;
        end
      end
      // a completed statement starts the token state afresh
      if (ev == EV_DIR || ev == EV_OPEN || ev == EV_CLOSE) begin
        lx_comment = 1'b0;
        lx_dq = 1'b0;
        lx_sq = 1'b0;
        lx_need_sep = 1'b0;
        lx_after_sep = 1'b1;
        lx_word_text = 1'b0;
        lx_have_words = 1'b0;
        lx_first = 0;
      end
    end
    if (ev == EV_DONE || ev == EV_ERR) lx_halted = 1'b1;
    r.is_word_text = text;
    r.word_done = fin;
    r.ev = ev;
    r.err = err;
    r.line = 16'(lx_line);
    r.dline = 16'(dline);
    r.depth = 4'(lx_depth);
  endtask

  // Drive one request, wait for acceptance, then queue its expected result
  task automatic send_req(input logic kind, input logic [7:0] b, input logic typed,
                          input lex_result_t want);
    lex_result_t pred;
    while (!steady && $urandom_range(99) < 13) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.kind <= kind;
    in_req.text_byte <= b;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    lex_byte_result(kind, b, pred);
    owe_result(typed ? want : pred);
    sent++;
    if (lx_depth > deepest) deepest = lx_depth;
    if (pred.ev == EV_DONE || pred.ev == EV_ERR) begin
      close_ev = pred.ev;
      close_err = pred.err;
    end
  endtask

  task automatic put(input logic [7:0] b);
    send_req(KIND_BYTE, b, 1'b0, NO_WANT);
  endtask

  // Separator run, sometimes followed by a comment line
  task automatic emit_gap();
    logic [7:0] b;
    int         n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(3))
        0: put(CH_SPACE);
        1: put(CH_TAB);
        2: put(CH_CR);
        default: put(CH_LF);
      endcase
    end
    if ($urandom_range(9) == 0) begin
      put(CH_HASH);
      repeat ($urandom_range(6)) begin
        do b = 8'($urandom_range(255)); while (b == CH_LF);
        put(b);
      end
      put(CH_LF);
    end
  endtask

  // Plain, double-quoted or single-quoted word with random content
  task automatic emit_word(output bit nonempty);
    logic [7:0] q;
    logic [7:0] b;
    int         n;
    int         sel;
    sel = $urandom_range(9);
    n = $urandom_range(5);
    if (sel < 6) begin
      do b = 8'($urandom_range(255)); while (!starts_word(b));
      put(b);
      repeat (n) begin
        do b = 8'($urandom_range(255)); while (blank(b) || b == CH_SEMI || b == CH_LBRACE);
        put(b);
      end
      nonempty = 1'b1;
    end else begin
      q = (sel < 8) ? CH_DQUOTE : CH_SQUOTE;
      put(q);
      repeat (n) begin
        do b = 8'($urandom_range(255)); while (b == q);
        put(b);
      end
      put(q);
      nonempty = (n != 0);
    end
  endtask

  // One to four words (plus a plain word if all were empty), then ';' or '{'
  task automatic emit_directive(input int how);
    int nw;
    bit any;
    bit got;
    bit open;
    nw = $urandom_range(1, 4);
    any = 1'b0;
    for (int i = 0; i < nw; i++) begin
      if (i != 0) emit_gap();
      emit_word(got);
      any |= got;
    end
    if (!any) begin
      emit_gap();
      put(8'h77);
    end
    if ($urandom_range(2) == 0) emit_gap();
    open = (how == END_OPEN) ||
           (how == END_ANY && lx_depth < DEF_MAX_DEPTH && $urandom_range(2) == 0);
    put(open ? CH_LBRACE : CH_SEMI);
  endtask

  task automatic emit_close();
    put(CH_RBRACE);
    if ($urandom_range(1) == 0) emit_gap();
  endtask

  // Ready of the result side
  always @(posedge clk) begin
    if (!rst_n) out_res.ready <= 1'b0;
    else out_res.ready <= steady || ($urandom_range(99) >= 13);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    lex_result_t got;
    lex_result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      got.is_word_text = out_res.is_word_text;
      got.word_done = out_res.word_done;
      got.ev = cdl_event_t'(out_res.event_res);
      got.err = cdl_error_t'(out_res.error_code);
      got.line = out_res.line_number;
      got.dline = out_res.directive_line;
      got.depth = out_res.nest_depth;
      if (owed_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("tb: result with no request pending: ev=%0d err=%0d line=%0d",
                   got.ev, got.err, got.line);
      end else begin
        want = owed_results.pop_front();
        checked++;
        if (got.is_word_text !== want.is_word_text || got.word_done !== want.word_done ||
            got.ev !== want.ev || got.err !== want.err || got.line !== want.line ||
            got.dline !== want.dline || got.depth !== want.depth) begin
          fails++;
          if (fails <= 10) begin
            $display("tb: %0d expected text=%0b done=%0b ev=%0d err=%0d ln=%0d dl=%0d dp=%0d",
                     checked, want.is_word_text, want.word_done, want.ev, want.err,
                     want.line, want.dline, want.depth);
            $display("tb: %0d actual   text=%0b done=%0b ev=%0d err=%0d ln=%0d dl=%0d dp=%0d",
                     checked, got.is_word_text, got.word_done, got.ev, got.err,
                     got.line, got.dline, got.depth);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: no progress after %0d cycles, %0d results owed", cycles, owed_results.size());
      $display("[config_directive_lexer] ERROR");
      $finish;
    end
  end

  initial begin
    int  rand_base;
    int  pick;
    bit  dived;
    bit  got;
    in_req.valid = 1'b0;
    in_req.kind = KIND_BYTE;
    in_req.text_byte = 8'h00;
    out_res.ready = 1'b0;
    rst_n = 1'b0;
    steady = 1'b0;
    dived = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening
    foreach (DIR_TAB[i])
      send_req(DIR_TAB[i].kind, DIR_TAB[i].b, DIR_TAB[i].typed, DIR_TAB[i].want);

    // well-formed directives and blocks with random content
    rand_base = sent;
    while (sent - rand_base < RAND_ITEMS) begin
      steady = (sent - rand_base >= 250) && (sent - rand_base < 400);
      if (!dived && sent - rand_base >= 300) begin
        // nest down to the maximum depth once
        while (lx_depth < DEF_MAX_DEPTH) emit_directive(END_OPEN);
        emit_directive(END_SEMI);
        dived = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) emit_directive(END_ANY);
      else if (pick < 80 && lx_depth > 0) emit_close();
      else emit_gap();
    end
    steady = 1'b0;

    // four line feeds, then one directive on the line after them
    repeat (4) put(CH_LF);
    put(8'h6B);
    put(CH_SPACE);
    put(8'h76);
    put(CH_SEMI);

    // close the stream with a clean end or one of the errors
    case ($urandom_range(9))
      FIN_DONE: begin
        while (lx_depth > 0) emit_close();
        emit_gap();
        send_req(KIND_EOF, 8'($urandom_range(255)), 1'b0, NO_WANT);
      end
      FIN_QUOTE_CHAR: begin
        put(CH_DQUOTE);
        put(8'h61);
        put(CH_DQUOTE);
        put(8'h78);
      end
      FIN_LONE_SEMI: begin
        put(CH_SPACE);
        put(CH_SEMI);
      end
      FIN_LONE_BRACE: put(CH_LBRACE);
      FIN_CLOSE_WORDS: begin
        put(8'h77);
        put(CH_SPACE);
        put(CH_RBRACE);
      end
      FIN_EOF_DIR: begin
        emit_word(got);
        send_req(KIND_EOF, 8'($urandom_range(255)), 1'b0, NO_WANT);
      end
      FIN_EMPTY_DIR: begin
        if ($urandom_range(1) == 0) begin
          put(CH_DQUOTE);
          put(CH_DQUOTE);
        end else begin
          put(CH_SQUOTE);
          put(CH_SQUOTE);
        end
        put($urandom_range(1) == 0 ? CH_SEMI : CH_LBRACE);
      end
      FIN_STRAY_CLOSE: begin
        while (lx_depth > 0) emit_close();
        put(CH_RBRACE);
      end
      FIN_EOF_BLOCK: begin
        if (lx_depth == 0) emit_directive(END_OPEN);
        send_req(KIND_EOF, 8'($urandom_range(255)), 1'b0, NO_WANT);
      end
      default: begin
        while (lx_depth < DEF_MAX_DEPTH) emit_directive(END_OPEN);
        put(8'h77);
        put(CH_LBRACE);
      end
    endcase

    // everything after the stream end must report halted
    repeat (8) send_req(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, NO_WANT);
    in_req.valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fails += owed_results.size();

    $display("tb: %0d requests (%0d random), %0d results checked, nesting reached %0d",
             sent, sent - 25, checked, deepest);
    $display("tb: line counter ended at %0d, stream ended with %s / %s",
             lx_line, close_ev.name(), close_err.name());
    if (fails == 0) begin
      $display("[config_directive_lexer] OK");
    end else begin
      $display("tb: %0d failures", fails);
      $display("[config_directive_lexer] ERROR");
    end
    $finish;
  end

endmodule
